@@ sv/rwsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rwsl_pkg;

    localparam int READ_SLOTS_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int OP_W     = 2;
    localparam int EXT_ID_W = 16;
    localparam int SLOT_W   = 3;
    localparam int CFG_W    = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLOSE = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/rwsl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/rwsl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwsl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output rwsl_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec = (r_state == ST_EXEC);

endmodule

`default_nettype wire

@@ sv/rwsl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwsl_dp #(
    parameter int READ_SLOTS  = rwsl_pkg::READ_SLOTS_DEF,
    parameter int QUEUE_DEPTH = rwsl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rwsl_pkg::ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rwsl_pkg::t_cmd                  i_cmd,
    input  wire logic [rwsl_pkg::OP_W-1:0]       i_op,
    input  wire logic [rwsl_pkg::EXT_ID_W-1:0]   i_context_id,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwsl_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_activated,
    output logic      [rwsl_pkg::EXT_ID_W-1:0]   o_activated_id,
    output logic      [rwsl_pkg::SLOT_W-1:0]     o_activated_slot,
    output logic                                 o_queued,
    output logic                                 o_found,
    output logic                                 o_overflow
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = rwsl_pkg::SLOT_W;

    logic [ID_BITS-1:0] id_in;

    rwsl_pkg::t_op                 r_op;
    logic [ID_BITS-1:0]            r_id;
    logic [rwsl_pkg::CFG_W-1:0]    r_cfg;

    logic                          r_wbusy, n_wbusy;
    logic [ID_BITS-1:0]            r_wowner, n_wowner;
    logic [READ_SLOTS-1:0]         r_rbusy, n_rbusy;
    logic [ID_BITS-1:0]            r_rowner [READ_SLOTS];
    logic [ID_BITS-1:0]            n_rowner [READ_SLOTS];

    logic [AW-1:0]                 r_rhead, n_rhead, r_whead, n_whead;
    logic [CW-1:0]                 r_rcount, n_rcount, r_wcount, n_wcount;
    logic [AW-1:0]                 rtail, wtail;
    logic [ID_BITS-1:0]            rhead_data, whead_data;
    logic                          rpush, rpop, wpush, wpop;

    logic                          r_done, n_done;
    logic                          r_act, n_act;
    logic [ID_BITS-1:0]            r_act_id, n_act_id;
    logic [SW-1:0]                 r_slot, n_slot;
    logic                          r_queued, n_queued;
    logic                          r_found, n_found;
    logic                          r_ovf, n_ovf;

    logic                          free_hit;
    logic [READ_SLOTS-1:0]         free_sel;
    logic [SW-1:0]                 free_slot;
    logic                          rmatch_hit;
    logic [READ_SLOTS-1:0]         rmatch_sel;
    logic [SW-1:0]                 rmatch_slot;
    logic                          rmatch_act;
    logic                          wmatch;
    logic                          rfull, wfull, to_write;

    generate
        if (ID_BITS >= rwsl_pkg::EXT_ID_W) begin : g_wide_id
            assign id_in          = ID_BITS'(i_context_id);
            assign o_activated_id = r_act_id[rwsl_pkg::EXT_ID_W-1:0];
        end else begin : g_narrow_id
            assign id_in          = i_context_id[ID_BITS-1:0];
            assign o_activated_id = rwsl_pkg::EXT_ID_W'(r_act_id);
        end
    endgenerate

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_tail(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW + 1)'(h) + (CW + 1)'(c);
        if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW + 1)'(QUEUE_DEPTH);
        end
        ptr_tail = sum[AW-1:0];
    endfunction

    assign rtail = ptr_tail(r_rhead, r_rcount);
    assign wtail = ptr_tail(r_whead, r_wcount);
    assign rfull = (r_rcount == CW'(QUEUE_DEPTH));
    assign wfull = (r_wcount == CW'(QUEUE_DEPTH));
    assign wmatch = r_wbusy && (r_wowner == r_id);
    assign to_write = (r_op == rwsl_pkg::OP_WRITE)
                   || ((r_op == rwsl_pkg::OP_READ) && (r_cfg == '0));

    // head entries are read every cycle; nothing is written in the idle cycle before exec
    rwsl_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_rfifo (
        .i_clk   (i_clk),
        .i_we    (rpush),
        .i_waddr (rtail),
        .i_wdata (r_id),
        .i_raddr (r_rhead),
        .o_rdata (rhead_data)
    );

    rwsl_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_wfifo (
        .i_clk   (i_clk),
        .i_we    (wpush),
        .i_waddr (wtail),
        .i_wdata (r_id),
        .i_raddr (r_whead),
        .o_rdata (whead_data)
    );

    // lowest free active read slot and lowest matching read slot
    always_comb begin
        free_hit    = 1'b0;
        free_sel    = '0;
        free_slot   = '0;
        rmatch_hit  = 1'b0;
        rmatch_sel  = '0;
        rmatch_slot = '0;
        rmatch_act  = 1'b0;
        for (int i = 0; i < READ_SLOTS; i++) begin
            if (!free_hit && !r_rbusy[i] && (i < int'(r_cfg))) begin
                free_hit    = 1'b1;
                free_sel[i] = 1'b1;
                free_slot   = SW'(i + 1);
            end
            if (!rmatch_hit && r_rbusy[i] && (r_rowner[i] == r_id)) begin
                rmatch_hit    = 1'b1;
                rmatch_sel[i] = 1'b1;
                rmatch_slot   = SW'(i + 1);
                rmatch_act    = (i < int'(r_cfg));
            end
        end
    end

    always_comb begin
        n_wbusy  = r_wbusy;
        n_wowner = r_wowner;
        n_rbusy  = r_rbusy;
        n_rowner = r_rowner;
        n_done   = i_cmd.exec;
        n_act    = 1'b0;
        n_act_id = '0;
        n_slot   = '0;
        n_queued = 1'b0;
        n_found  = 1'b0;
        n_ovf    = 1'b0;
        rpush    = 1'b0;
        rpop     = 1'b0;
        wpush    = 1'b0;
        wpop     = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                rwsl_pkg::OP_READ, rwsl_pkg::OP_WRITE: begin
                    if (to_write) begin
                        if (!r_wbusy) begin
                            n_wbusy  = 1'b1;
                            n_wowner = r_id;
                            n_act    = 1'b1;
                            n_act_id = r_id;
                        end else if (wfull) begin
                            n_ovf = 1'b1;
                        end else begin
                            wpush    = 1'b1;
                            n_queued = 1'b1;
                        end
                    end else if ((r_rcount == '0) && free_hit) begin
                        for (int i = 0; i < READ_SLOTS; i++) begin
                            if (free_sel[i]) begin
                                n_rbusy[i]  = 1'b1;
                                n_rowner[i] = r_id;
                            end
                        end
                        n_act    = 1'b1;
                        n_act_id = r_id;
                        n_slot   = free_slot;
                    end else if (rfull) begin
                        n_ovf = 1'b1;
                    end else begin
                        rpush    = 1'b1;
                        n_queued = 1'b1;
                    end
                end
                rwsl_pkg::OP_CLOSE: begin
                    if (wmatch) begin
                        n_found = 1'b1;
                        if (r_wcount != '0) begin
                            wpop     = 1'b1;
                            n_wowner = whead_data;
                            n_act    = 1'b1;
                            n_act_id = whead_data;
                        end else begin
                            n_wbusy  = 1'b0;
                            n_wowner = '0;
                        end
                    end else if (rmatch_hit) begin
                        n_found = 1'b1;
                        if (rmatch_act && (r_rcount != '0)) begin
                            rpop     = 1'b1;
                            n_act    = 1'b1;
                            n_act_id = rhead_data;
                            n_slot   = rmatch_slot;
                        end
                        for (int i = 0; i < READ_SLOTS; i++) begin
                            if (rmatch_sel[i]) begin
                                if (rmatch_act && (r_rcount != '0)) begin
                                    n_rowner[i] = rhead_data;
                                end else begin
                                    n_rbusy[i]  = 1'b0;
                                    n_rowner[i] = '0;
                                end
                            end
                        end
                    end
                end
                rwsl_pkg::OP_QUERY: begin
                    n_found = wmatch || rmatch_hit;
                end
                default: begin
                    n_found = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_rhead  = rpop ? ptr_inc(r_rhead) : r_rhead;
        n_whead  = wpop ? ptr_inc(r_whead) : r_whead;
        n_rcount = r_rcount + CW'(rpush) - CW'(rpop);
        n_wcount = r_wcount + CW'(wpush) - CW'(wpop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= rwsl_pkg::CFG_RESET;
            r_wbusy  <= 1'b0;
            r_wowner <= '0;
            r_rbusy  <= '0;
            for (int i = 0; i < READ_SLOTS; i++) begin
                r_rowner[i] <= '0;
            end
            r_rhead  <= '0;
            r_whead  <= '0;
            r_rcount <= '0;
            r_wcount <= '0;
            r_done   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_wbusy  <= n_wbusy;
            r_wowner <= n_wowner;
            r_rbusy  <= n_rbusy;
            r_rowner <= n_rowner;
            r_rhead  <= n_rhead;
            r_whead  <= n_whead;
            r_rcount <= n_rcount;
            r_wcount <= n_wcount;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= rwsl_pkg::t_op'(i_op);
            r_id <= id_in;
        end
        if (i_cmd.exec) begin
            r_act    <= n_act;
            r_act_id <= n_act_id;
            r_slot   <= n_slot;
            r_queued <= n_queued;
            r_found  <= n_found;
            r_ovf    <= n_ovf;
        end
    end

    assign o_done           = r_done;
    assign o_activated      = r_act;
    assign o_activated_slot = r_slot;
    assign o_queued         = r_queued;
    assign o_found          = r_found;
    assign o_overflow       = r_ovf;

endmodule

`default_nettype wire

@@ sv/read_write_slot_lock_manager_core.sv @@
// Reader/writer slot lock manager: one write slot, READ_SLOTS read slots and
// two wait queues (read and write) of QUEUE_DEPTH ids each.
// Request channel: present i_op and i_context_id with start high; the request
// is taken at a rising edge where start is high and busy is low.
// Ops: read lock, write lock, close (free or hand over the slot), query.
// Result channel: o_done is high for exactly one cycle with the result fields;
// the receiver cannot hold it off and must take it in that cycle.
// Sequence: the request is registered, then executed in the execute state,
// then the registered result is placed on the ports.
// No new request is taken while busy is high; busy is high in the execute
// state, which waits on the registered read of the wait queue heads.
// Configuration: i_cfg_we writes active_read_slots from i_cfg_wdata; the user
// must write only while no request is in flight; the block does not check it.
// Reset (i_rst_n low, synchronous): all slots free, both queues empty,
// active_read_slots = 4, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module read_write_slot_lock_manager_core #(
    parameter int READ_SLOTS  = rwsl_pkg::READ_SLOTS_DEF,
    parameter int QUEUE_DEPTH = rwsl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rwsl_pkg::ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [rwsl_pkg::OP_W-1:0]       i_op,
    input  wire logic [rwsl_pkg::EXT_ID_W-1:0]   i_context_id,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwsl_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_activated,
    output logic      [rwsl_pkg::EXT_ID_W-1:0]   o_activated_id,
    output logic      [rwsl_pkg::SLOT_W-1:0]     o_activated_slot,
    output logic                                 o_queued,
    output logic                                 o_found,
    output logic                                 o_overflow
);

    rwsl_pkg::t_cmd cmd;

    rwsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    rwsl_dp #(
        .READ_SLOTS  (READ_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_context_id     (i_context_id),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_activated      (o_activated),
        .o_activated_id   (o_activated_id),
        .o_activated_slot (o_activated_slot),
        .o_queued         (o_queued),
        .o_found          (o_found),
        .o_overflow       (o_overflow)
    );

endmodule

`default_nettype wire

@@ sv/rwsl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwsl_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_activated,
    input wire logic o_queued,
    input wire logic o_overflow
);

    // every taken request must be followed by a result on o_done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("request without result");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy longer than one cycle");

    a_done_only_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without request");

    a_outcome_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_queued && o_overflow) && !(o_activated && (o_queued || o_overflow)))
        else $error("conflicting outcome flags");

endmodule

bind read_write_slot_lock_manager_core rwsl_checker u_rwsl_checker (.*);

`default_nettype wire
